@@ rtl/wgpk_pkg.sv @@
// Package: shared types, constants and weight lookup for the pair kernel.
`default_nettype none
package wgpk_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned ElemW     = 7;
  localparam int unsigned GammaW    = 16;
  localparam int unsigned WeightW   = 10;
  localparam int unsigned ExpW      = 16;
  localparam int unsigned D2W       = 34;
  localparam int unsigned ProdW     = GammaW + D2W;
  localparam int unsigned AShift    = 13;
  localparam int unsigned AW        = ProdW - AShift;
  localparam int unsigned AIntMaxW  = ExpW + 5;
  localparam int unsigned Log2eW    = 31;
  localparam int unsigned TW        = AIntMaxW + Log2eW - 30;
  localparam int unsigned KW        = ExpW + 5;
  localparam int unsigned WtermW    = WeightW + ExpW;
  localparam int unsigned WsqW      = 2 * WeightW;
  localparam int unsigned AccW      = 48;
  localparam int unsigned WsqAccW   = 40;
  localparam int unsigned DivW      = WsqAccW + ExpW;
  localparam int unsigned QW        = 26;
  localparam int unsigned SimW      = 24;
  localparam int unsigned NoElem    = 9;

  localparam logic [Log2eW-1:0] Log2eQ30   = 31'd1549082005;
  localparam logic [QW-1:0]     RatioScale = 26'd65536000;
  localparam logic [GammaW-1:0] GammaReset = 16'd4096;

  typedef struct packed {
    logic [WtermW-1:0] wterm;
    logic [WsqW-1:0]   wsq;
    logic              last;
  } fentry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fstat_t;

  typedef logic [WeightW-1:0] wrow_t [NoElem];
  localparam wrow_t WTable [NoElem] = '{
    '{10'd42,  10'd67,  10'd63,  10'd69,  10'd68,  10'd115, 10'd115, 10'd136, 10'd162},
    '{10'd67,  10'd107, 10'd100, 10'd111, 10'd108, 10'd183, 10'd183, 10'd215, 10'd258},
    '{10'd63,  10'd100, 10'd95,  10'd105, 10'd102, 10'd172, 10'd172, 10'd203, 10'd243},
    '{10'd69,  10'd111, 10'd105, 10'd116, 10'd112, 10'd190, 10'd190, 10'd224, 10'd268},
    '{10'd68,  10'd108, 10'd102, 10'd112, 10'd109, 10'd185, 10'd185, 10'd217, 10'd259},
    '{10'd115, 10'd183, 10'd172, 10'd190, 10'd185, 10'd314, 10'd314, 10'd369, 10'd442},
    '{10'd115, 10'd183, 10'd172, 10'd190, 10'd185, 10'd314, 10'd314, 10'd369, 10'd442},
    '{10'd136, 10'd215, 10'd203, 10'd224, 10'd217, 10'd369, 10'd369, 10'd434, 10'd522},
    '{10'd162, 10'd258, 10'd243, 10'd268, 10'd259, 10'd442, 10'd442, 10'd522, 10'd623}
  };

  function automatic logic [3:0] elem_idx(input logic [ElemW-1:0] z);
    logic [3:0] r;
    case (z)
      7'd1:    r = 4'd0;
      7'd6:    r = 4'd1;
      7'd7:    r = 4'd2;
      7'd8:    r = 4'd3;
      7'd9:    r = 4'd4;
      7'd16:   r = 4'd5;
      7'd17:   r = 4'd6;
      7'd35:   r = 4'd7;
      7'd53:   r = 4'd8;
      default: r = 4'(NoElem);
    endcase
    return r;
  endfunction

  // table is symmetric, so the pair order does not matter
  function automatic logic [WeightW-1:0] pair_weight(input logic [ElemW-1:0] e1,
                                                     input logic [ElemW-1:0] e2);
    logic [3:0] a;
    logic [3:0] b;
    a = elem_idx(e1);
    b = elem_idx(e2);
    if (a == 4'(NoElem) || b == 4'(NoElem)) return '0;
    return WTable[a][b];
  endfunction

endpackage
`default_nettype wire

@@ rtl/wgpk_front.sv @@
// Front: accepts a pair word and computes its weight and Gaussian term step by step.
`default_nettype none
module wgpk_front import wgpk_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [GammaW-1:0]        gamma_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [ElemW-1:0]         first_element_i,
  input  wire logic [ElemW-1:0]         second_element_i,
  input  wire logic signed [CoordW-1:0] first_x_i,
  input  wire logic signed [CoordW-1:0] first_y_i,
  input  wire logic signed [CoordW-1:0] first_z_i,
  input  wire logic signed [CoordW-1:0] second_x_i,
  input  wire logic signed [CoordW-1:0] second_y_i,
  input  wire logic signed [CoordW-1:0] second_z_i,
  input  wire logic                     last_pair_i,
  input  wire fstat_t                   fstat_i,
  output logic                          push_o,
  output fentry_t                       push_data_o
);

  typedef enum logic [3:0] {
    F_IDLE, F_SQ, F_SUM, F_MUL, F_LOG, F_KCOEF, F_POLY, F_EXP, F_WMUL, F_PUSH
  } fstate_e;

  fstate_e              state_q;
  logic [CoordW-1:0]    dx_q, dy_q, dz_q;
  logic [2*CoordW-1:0]  sx_q, sy_q, sz_q;
  logic [D2W-1:0]       d2_q;
  logic [AW-1:0]        a_q;
  logic                 zero_q;
  logic [TW-1:0]        t_q;
  logic [KW-1:0]        k_q;
  logic [ExpW-1:0]      term_q;
  logic [ExpW-1:0]      e_q;
  logic [WeightW-1:0]   w_q;
  logic                 last_q;
  fentry_t              ent_q;

  function automatic logic [CoordW-1:0] absdiff(input logic signed [CoordW-1:0] p,
                                                input logic signed [CoordW-1:0] q);
    logic signed [CoordW:0] d;
    d = CoordW'(0) + ({p[CoordW-1], p} - {q[CoordW-1], q});
    if (d[CoordW]) d = -d;
    return d[CoordW-1:0];
  endfunction

  logic [ProdW-1:0]           prod;
  logic [AIntMaxW+Log2eW-1:0] lprod;
  logic [ExpW-1:0]            f;
  logic [ExpW+KW-1:0]         pprod;
  logic [ExpW:0]              p;
  logic [ExpW:0]              psh;

  always_comb begin
    prod  = ProdW'(gamma_i) * ProdW'(d2_q);
    lprod = (AIntMaxW+Log2eW)'(a_q[AIntMaxW-1:0]) * (AIntMaxW+Log2eW)'(Log2eQ30);
    f     = t_q[ExpW-1:0];
    pprod = (ExpW+KW)'(f) * (ExpW+KW)'(k_q);
    p     = (ExpW+1)'(1 << ExpW) - (ExpW+1)'(term_q);
    psh   = p >> t_q[TW-1:ExpW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            dx_q    <= absdiff(first_x_i, second_x_i);
            dy_q    <= absdiff(first_y_i, second_y_i);
            dz_q    <= absdiff(first_z_i, second_z_i);
            w_q     <= pair_weight(first_element_i, second_element_i);
            last_q  <= last_pair_i;
            state_q <= F_SQ;
          end
        end
        F_SQ: begin
          sx_q    <= (2*CoordW)'(dx_q) * (2*CoordW)'(dx_q);
          sy_q    <= (2*CoordW)'(dy_q) * (2*CoordW)'(dy_q);
          sz_q    <= (2*CoordW)'(dz_q) * (2*CoordW)'(dz_q);
          state_q <= F_SUM;
        end
        F_SUM: begin
          d2_q    <= D2W'(sx_q) + D2W'(sy_q) + D2W'(sz_q);
          state_q <= F_MUL;
        end
        F_MUL: begin
          a_q     <= prod[ProdW-1:AShift];
          state_q <= F_LOG;
        end
        F_LOG: begin
          zero_q  <= |a_q[AW-1:AIntMaxW];
          t_q     <= lprod[AIntMaxW+Log2eW-1:30];
          state_q <= F_KCOEF;
        end
        F_KCOEF: begin
          k_q     <= KW'(21 << ExpW) - (KW'({f, 2'b00}) + KW'(f));
          state_q <= F_POLY;
        end
        F_POLY: begin
          term_q  <= pprod[ExpW+KW-1:ExpW+5];
          state_q <= F_EXP;
        end
        F_EXP: begin
          if (zero_q) e_q <= '0;
          else if (psh[ExpW]) e_q <= '1;
          else e_q <= psh[ExpW-1:0];
          state_q <= F_WMUL;
        end
        F_WMUL: begin
          ent_q.wterm <= WtermW'(w_q) * WtermW'(e_q);
          ent_q.wsq   <= WsqW'(w_q) * WsqW'(w_q);
          ent_q.last  <= last_q;
          state_q     <= F_PUSH;
        end
        F_PUSH: begin
          if (!fstat_i.full) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !fstat_i.full;
  assign push_data_o = ent_q;

endmodule
`default_nettype wire

@@ rtl/wgpk_fifo.sv @@
// Four-word queue between the front and the back.
`default_nettype none
module wgpk_fifo import wgpk_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire fentry_t push_data_i,
  input  wire logic    pop_i,
  output fentry_t      pop_data_o,
  output fstat_t       stat_o
);

  fentry_t    mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  assign pop_data_o   = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 3'd4);
  assign stat_o.empty = (cnt_q == 3'd0);

endmodule
`default_nettype wire

@@ rtl/wgpk_back.sv @@
// Back: accumulates the two sums, divides on the last word and holds the result register.
`default_nettype none
module wgpk_back import wgpk_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire fentry_t pop_data_i,
  input  wire fstat_t  fstat_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output logic [SimW-1:0] similarity_o,
  output logic         zero_weight_o
);

  typedef enum logic [1:0] {B_ACC, B_DIV, B_OUT} bstate_e;

  bstate_e             state_q;
  logic [AccW-1:0]     ws_q;
  logic [WsqAccW-1:0]  wsq_q;
  logic [AccW-1:0]     s_q;
  logic [DivW-1:0]     d_q;
  logic [DivW-1:0]     r_q;
  logic [QW-1:0]       q_q;
  logic [4:0]          bit_q;
  logic                phase_q;
  logic [SimW-1:0]     sim_q;
  logic                zw_q;
  logic                out_valid_q;
  logic [SimW-1:0]     out_sim_q;
  logic                out_zw_q;

  logic [AccW:0]      ws_sum;
  logic [WsqAccW:0]   wsq_sum;
  logic [AccW-1:0]    ws_n;
  logic [WsqAccW-1:0] wsq_n;
  logic [DivW:0]      r_try;
  logic               r_ge;
  logic               more;
  logic               out_free;
  logic               out_load;

  always_comb begin
    ws_sum  = (AccW+1)'(ws_q) + (AccW+1)'(pop_data_i.wterm);
    wsq_sum = (WsqAccW+1)'(wsq_q) + (WsqAccW+1)'(pop_data_i.wsq);
    ws_n    = ws_sum[AccW] ? '1 : ws_sum[AccW-1:0];
    wsq_n   = wsq_sum[WsqAccW] ? '1 : wsq_sum[WsqAccW-1:0];
    if (!phase_q) r_try = {r_q, 1'b0};
    else r_try = (DivW+1)'(r_q) + (DivW+1)'(s_q);
    r_ge     = (r_try >= (DivW+1)'(d_q));
    more     = !phase_q && RatioScale[bit_q];
    out_free = !out_valid_q || !out_stall_i;
    out_load = (state_q == B_OUT) && out_free;
  end

  assign pop_o = (state_q == B_ACC) && !fstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_ACC;
      ws_q        <= '0;
      wsq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      case (state_q)
        B_ACC: begin
          if (pop_o) begin
            if (pop_data_i.last) begin
              ws_q  <= '0;
              wsq_q <= '0;
              s_q   <= ws_n;
              d_q   <= {wsq_n, ExpW'(0)};
              r_q   <= '0;
              q_q   <= '0;
              bit_q <= 5'(QW - 1);
              phase_q <= 1'b0;
              if (wsq_n == '0) begin
                sim_q   <= '0;
                zw_q    <= 1'b1;
                state_q <= B_OUT;
              end else if ((DivW)'(ws_n) >= {wsq_n, ExpW'(0)}) begin
                sim_q   <= '1;
                zw_q    <= 1'b0;
                state_q <= B_OUT;
              end else begin
                zw_q    <= 1'b0;
                state_q <= B_DIV;
              end
            end else begin
              ws_q  <= ws_n;
              wsq_q <= wsq_n;
            end
          end
        end
        B_DIV: begin
          if (r_ge) begin
            r_q <= DivW'(r_try - (DivW+1)'(d_q));
          end else begin
            r_q <= r_try[DivW-1:0];
          end
          q_q <= (phase_q ? q_q : {q_q[QW-2:0], 1'b0}) + QW'(r_ge);
          if (more) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            if (bit_q == '0) state_q <= B_OUT;
            else bit_q <= bit_q - 5'd1;
          end
          if (!more && bit_q == '0) begin
            if (((phase_q ? q_q : {q_q[QW-2:0], 1'b0}) + QW'(r_ge)) >> SimW != '0) begin
              sim_q <= '1;
            end else begin
              sim_q <= SimW'((phase_q ? q_q : {q_q[QW-2:0], 1'b0}) + QW'(r_ge));
            end
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_sim_q   <= sim_q;
            out_zw_q    <= zw_q;
            state_q     <= B_ACC;
          end
        end
        default: state_q <= B_ACC;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign similarity_o  = out_sim_q;
  assign zero_weight_o = out_zw_q;

endmodule
`default_nettype wire

@@ rtl/weighted_gaussian_pair_kernel.sv @@
// Top level of the weighted Gaussian pair kernel.
// Input channel: one atom pair per word (two element numbers, two 3D points in
// signed Q7.8, last_pair). A word is taken when in_valid_i is high and
// in_stall_o is low. The front runs its multi-step exponential evaluation on
// one word at a time and takes no new word until that one is pushed.
// A four-word queue feeds the back, which adds each word into the sums as it
// pops it. On a last word the back runs a restoring division, one step per
// scale bit plus an extra step for each set bit, and then loads
// the output register; words for the next comparison keep entering the front
// and queue meanwhile. Division is skipped for zero weight or a saturated ratio.
// Output channel: similarity_o (unsigned Q8.16) and
// zero_weight_o, taken when out_valid_o is high and out_stall_i is low.
// A stalled result holds; the queue then fills and in_stall_o rises.
// cfg_we_i writes gamma (Q4.12) from cfg_wdata_i; write only when idle.
// Reset clears both sums, empties the queue and sets gamma to 1.0.
`default_nettype none
module weighted_gaussian_pair_kernel import wgpk_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [GammaW-1:0]        cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [ElemW-1:0]         first_element_i,
  input  wire logic [ElemW-1:0]         second_element_i,
  input  wire logic signed [CoordW-1:0] first_x_i,
  input  wire logic signed [CoordW-1:0] first_y_i,
  input  wire logic signed [CoordW-1:0] first_z_i,
  input  wire logic signed [CoordW-1:0] second_x_i,
  input  wire logic signed [CoordW-1:0] second_y_i,
  input  wire logic signed [CoordW-1:0] second_z_i,
  input  wire logic                     last_pair_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [SimW-1:0]               similarity_o,
  output logic                          zero_weight_o
);

  logic [GammaW-1:0] gamma_q;
  logic              push, pop;
  fentry_t           push_data, pop_data;
  fstat_t            fstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GammaReset;
    end else if (cfg_we_i) begin
      gamma_q <= cfg_wdata_i;
    end
  end

  wgpk_front u_front (
    .clk_i, .rst_ni,
    .gamma_i(gamma_q),
    .in_valid_i, .in_stall_o,
    .first_element_i, .second_element_i,
    .first_x_i, .first_y_i, .first_z_i,
    .second_x_i, .second_y_i, .second_z_i,
    .last_pair_i,
    .fstat_i(fstat),
    .push_o(push),
    .push_data_o(push_data)
  );

  wgpk_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data),
    .pop_i(pop), .pop_data_o(pop_data),
    .stat_o(fstat)
  );

  wgpk_back u_back (
    .clk_i, .rst_ni,
    .pop_data_i(pop_data),
    .fstat_i(fstat),
    .pop_o(pop),
    .out_valid_o, .out_stall_i,
    .similarity_o, .zero_weight_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fstat.full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && fstat.empty)) else $error("queue underflow");
  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_weight_o) |-> (similarity_o == '0)) else $error("zero weight result");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("front not busy");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench for the weighted Gaussian pair kernel: random and directed pair streams.
`timescale 1ns / 100ps
`default_nettype none

class similarity_board;
  logic [15:0] gamma_q;
  logic [47:0] wsum;
  logic [39:0] wsq_sum;
  logic [23:0] exp_sim[$];
  logic        exp_zero[$];
  int          mismatches;

  function new();
    gamma_q = 16'd4096;
    wsum = '0;
    wsq_sum = '0;
    mismatches = 0;
  endfunction

  function int elem_slot(logic [6:0] z);
    case (z)
      7'd1: return 0;
      7'd6: return 1;
      7'd7: return 2;
      7'd8: return 3;
      7'd9: return 4;
      7'd16: return 5;
      7'd17: return 6;
      7'd35: return 7;
      7'd53: return 8;
      default: return -1;
    endcase
  endfunction

  function logic [9:0] steric_weight(logic [6:0] e1, logic [6:0] e2);
    int a, b;
    logic [9:0] tbl [9][9];
    tbl = '{
      '{10'd42, 10'd67, 10'd63, 10'd69, 10'd68, 10'd115, 10'd115, 10'd136, 10'd162},
      '{10'd67, 10'd107, 10'd100, 10'd111, 10'd108, 10'd183, 10'd183, 10'd215, 10'd258},
      '{10'd63, 10'd100, 10'd95, 10'd105, 10'd102, 10'd172, 10'd172, 10'd203, 10'd243},
      '{10'd69, 10'd111, 10'd105, 10'd116, 10'd112, 10'd190, 10'd190, 10'd224, 10'd268},
      '{10'd68, 10'd108, 10'd102, 10'd112, 10'd109, 10'd185, 10'd185, 10'd217, 10'd259},
      '{10'd115, 10'd183, 10'd172, 10'd190, 10'd185, 10'd314, 10'd314, 10'd369, 10'd442},
      '{10'd115, 10'd183, 10'd172, 10'd190, 10'd185, 10'd314, 10'd314, 10'd369, 10'd442},
      '{10'd136, 10'd215, 10'd203, 10'd224, 10'd217, 10'd369, 10'd369, 10'd434, 10'd522},
      '{10'd162, 10'd258, 10'd243, 10'd268, 10'd259, 10'd442, 10'd442, 10'd522, 10'd623}};
    a = elem_slot(e1);
    b = elem_slot(e2);
    if (a < 0 || b < 0) return '0;
    return tbl[a][b];
  endfunction

  function logic [16:0] gauss_term(logic [63:0] d2);
    logic [63:0] a, t, n, f, term, p;
    a = (64'(gamma_q) * d2) >> 13;
    if ((a >> 16) >= 32) return '0;
    t = (a * 64'd1549082005) >> 30;
    n = t >> 16;
    f = t & 64'hFFFF;
    term = (f * (21 * 64'd65536 - 5 * f)) >> 21;
    p = 64'd65536 - term;
    if (n >= 64) return '0;
    p = p >> n;
    if (p > 64'hFFFF) p = 64'hFFFF;
    return p[16:0];
  endfunction

  function logic [23:0] quotient(logic [63:0] s, logic [63:0] d);
    logic [127:0] q;
    if (s >= d) return 24'hFFFFFF;
    q = (128'(s) * 128'd65536000) / 128'(d);
    if (q > 128'hFFFFFF) return 24'hFFFFFF;
    return q[23:0];
  endfunction

  function void note_pair(logic [6:0] e1, logic [6:0] e2, logic signed [15:0] c[6],
                          logic last);
    logic [63:0] d2, w, v, acc_max, wsq_max;
    longint dd;
    w = steric_weight(e1, e2);
    d2 = 0;
    for (int k = 0; k < 3; k++) begin
      dd = longint'(c[k]) - longint'(c[k+3]);
      d2 += 64'(dd * dd);
    end
    acc_max = 64'hFFFF_FFFF_FFFF;
    wsq_max = 64'hFF_FFFF_FFFF;
    v = w * gauss_term(d2);
    wsum = (v > acc_max - wsum) ? acc_max[47:0] : wsum + v[47:0];
    v = w * w;
    wsq_sum = (v > wsq_max - wsq_sum) ? wsq_max[39:0] : wsq_sum + v[39:0];
    if (!last) return;
    if (wsq_sum == 0) begin
      exp_sim.push_back('0);
      exp_zero.push_back(1'b1);
    end else begin
      exp_sim.push_back(quotient(wsum, 64'(wsq_sum) << 16));
      exp_zero.push_back(1'b0);
    end
    wsum = '0;
    wsq_sum = '0;
  endfunction

  function void check_result(logic [23:0] sim, logic zero);
    logic [23:0] es;
    logic ez;
    if (exp_sim.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result sim=%0d zero=%0b", sim, zero);
      return;
    end
    es = exp_sim.pop_front();
    ez = exp_zero.pop_front();
    if (sim !== es || zero !== ez) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result: expected sim=%0d zero=%0b, got sim=%0d zero=%0b",
                 es, ez, sim, zero);
    end
  endfunction
endclass

module tb;
  import wgpk_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [GammaW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ElemW-1:0] first_element_i = '0, second_element_i = '0;
  logic signed [CoordW-1:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic signed [CoordW-1:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic last_pair_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SimW-1:0] similarity_o;
  logic zero_weight_o;

  similarity_board board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  localparam int QuietLimit = 20000;
  logic [6:0] known_elems [9] = '{7'd1, 7'd6, 7'd7, 7'd8, 7'd9, 7'd16, 7'd17, 7'd35, 7'd53};

  weighted_gaussian_pair_kernel i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(similarity_o, zero_weight_o);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // valid stays high after an accept until the next word or an idle cycle replaces it
  task automatic send_pair(logic [6:0] e1, logic [6:0] e2, logic signed [15:0] c[6],
                           logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_element_i <= e1;
    second_element_i <= e2;
    first_x_i <= c[0];
    first_y_i <= c[1];
    first_z_i <= c[2];
    second_x_i <= c[3];
    second_y_i <= c[4];
    second_z_i <= c[5];
    last_pair_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pair(e1, e2, c, last);
  endtask

  function automatic logic [6:0] pick_elem();
    if ($urandom_range(9) < 8) return known_elems[$urandom_range(8)];
    return 7'($urandom);
  endfunction

  task automatic send_random(logic last);
    logic signed [15:0] c[6];
    int spread;
    spread = $urandom_range(3);
    for (int k = 0; k < 6; k++) begin
      case (spread)
        0: c[k] = 16'($urandom);
        1: c[k] = 16'(int'($urandom_range(1023)) - 512);
        default: c[k] = 16'(int'($urandom_range(255)) - 128);
      endcase
    end
    if (spread == 3) for (int k = 0; k < 3; k++) c[k+3] = c[k];
    send_pair(pick_elem(), pick_elem(), c, last);
  endtask

  task automatic drain_and_set_gamma(logic [15:0] g);
    in_valid_i <= 1'b0;
    while (board.exp_sim.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.gamma_q = g;
  endtask

  task automatic random_phase(int n);
    int len;
    while (n > 0) begin
      len = $urandom_range(8, 1);
      for (int k = 0; k < len; k++) send_random(k == len - 1);
      n -= len;
    end
  endtask

  initial begin
    logic signed [15:0] c[6];
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // zero distance, coordinate extremes, unknown elements, empty-weight comparison
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_pair(7'd53, 7'd53, c, 1'b1);
    c = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000};
    send_pair(7'd1, 7'd6, c, 1'b0);
    c = '{16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    send_pair(7'd6, 7'd1, c, 1'b1);
    send_pair(7'd0, 7'd127, c, 1'b1);
    send_pair(7'd127, 7'd1, c, 1'b0);
    send_pair(7'd2, 7'd0, c, 1'b1);
    c = '{16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    for (int k = 0; k < 9; k++) send_pair(known_elems[k], known_elems[8 - k], c, k == 8);
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    for (int k = 0; k < 5; k++) send_pair(7'd53, 7'd53, c, k == 4);
    drain_and_set_gamma(16'd0);
    c = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000};
    send_pair(7'd35, 7'd17, c, 1'b1);
    send_random(1'b1);
    drain_and_set_gamma(16'hFFFF);
    c = '{16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_pair(7'd8, 7'd7, c, 1'b1);
    send_random(1'b1);

    send_idle_pct = 11;
    recv_idle_pct = 81;
    drain_and_set_gamma(16'd4096);
    random_phase(200);
    send_idle_pct = 81;
    recv_idle_pct = 11;
    drain_and_set_gamma(16'($urandom));
    random_phase(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_and_set_gamma(16'($urandom_range(512, 1)));
    random_phase(200);

    in_valid_i <= 1'b0;
    while (board.exp_sim.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

`default_nettype wire
